/* sv/ddhc_pkg.sv */
`timescale 1ns / 1ps

package ddhc_pkg;

  // Datapath operation codes, one per controller step
  localparam logic [3:0] OP_IDLE  = 4'd0;
  localparam logic [3:0] OP_MUL_W = 4'd1;
  localparam logic [3:0] OP_MUL_H = 4'd2;
  localparam logic [3:0] OP_SUM   = 4'd3;
  localparam logic [3:0] OP_MOD   = 4'd4;
  localparam logic [3:0] OP_MUL_A = 4'd5;
  localparam logic [3:0] OP_MUL_B = 4'd6;
  localparam logic [3:0] OP_MUL_C = 4'd7;
  localparam logic [3:0] OP_MUL_D = 4'd8;
  localparam logic [3:0] OP_LIM_A = 4'd9;
  localparam logic [3:0] OP_LIM_B = 4'd10;
  localparam logic [3:0] OP_MUL_R = 4'd11;
  localparam logic [3:0] OP_MUL_L = 4'd12;
  localparam logic [3:0] OP_OUT   = 4'd13;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_GAIN_SPEED_FEEDBACK = 3'd0;
  localparam logic [2:0] REG_GAIN_SPEED_TARGET   = 3'd1;
  localparam logic [2:0] REG_GAIN_HEADING        = 3'd2;
  localparam logic [2:0] REG_GAIN_TURN_RATE      = 3'd3;
  localparam logic [2:0] REG_TURN_SCALE          = 3'd4;
  localparam logic [2:0] REG_HALF_PERIOD         = 3'd5;
  localparam logic [2:0] REG_PWM_TOP             = 3'd6;

  // Heading reduction: offset the sum by 256 turns, then strip 2pi << k for k = 8..0
  localparam logic [3:0]  MOD_FIRST   = 4'd8;
  localparam logic [26:0] HEAD_OFFSET = 27'd6588416;

  localparam logic [1:0] DIR_STOP    = 2'd0;
  localparam logic [1:0] DIR_FORWARD = 2'd1;
  localparam logic [1:0] DIR_REVERSE = 2'd2;

  typedef struct packed {
    logic       load_in;
    logic [3:0] op;
    logic [3:0] mod_k;
  } ddhc_cmd_t;

endpackage

/* sv/ddhc_ctrl.sv */
`timescale 1ns / 1ps

module ddhc_ctrl
  import ddhc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  output ddhc_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL_W = 4'd1;
  localparam logic [3:0] S_MUL_H = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_MOD   = 4'd4;
  localparam logic [3:0] S_MUL_A = 4'd5;
  localparam logic [3:0] S_MUL_B = 4'd6;
  localparam logic [3:0] S_MUL_C = 4'd7;
  localparam logic [3:0] S_MUL_D = 4'd8;
  localparam logic [3:0] S_LIM_A = 4'd9;
  localparam logic [3:0] S_LIM_B = 4'd10;
  localparam logic [3:0] S_MUL_R = 4'd11;
  localparam logic [3:0] S_MUL_L = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0] state, state_next;
  logic [3:0] mod_k, mod_k_next;
  logic       out_valid, out_valid_next;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign out_free = !out_valid || m_tready;

  always_comb begin
    state_next     = state;
    mod_k_next     = mod_k;
    out_valid_next = out_valid && !m_tready;
    cmd.load_in    = 1'b0;
    cmd.op         = OP_IDLE;
    cmd.mod_k      = mod_k;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MUL_W;
        end
      end
      S_MUL_W: begin
        cmd.op     = OP_MUL_W;
        state_next = S_MUL_H;
      end
      S_MUL_H: begin
        cmd.op     = OP_MUL_H;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op     = OP_SUM;
        mod_k_next = MOD_FIRST;
        state_next = S_MOD;
      end
      S_MOD: begin
        cmd.op = OP_MOD;
        if (mod_k == 4'd0) begin
          state_next = S_MUL_A;
        end else begin
          mod_k_next = mod_k - 4'd1;
        end
      end
      S_MUL_A: begin
        cmd.op     = OP_MUL_A;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.op     = OP_MUL_B;
        state_next = S_MUL_C;
      end
      S_MUL_C: begin
        cmd.op     = OP_MUL_C;
        state_next = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.op     = OP_MUL_D;
        state_next = S_LIM_A;
      end
      S_LIM_A: begin
        cmd.op     = OP_LIM_A;
        state_next = S_LIM_B;
      end
      S_LIM_B: begin
        cmd.op     = OP_LIM_B;
        state_next = S_MUL_R;
      end
      S_MUL_R: begin
        cmd.op     = OP_MUL_R;
        state_next = S_MUL_L;
      end
      S_MUL_L: begin
        cmd.op     = OP_MUL_L;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.op         = OP_OUT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mod_k     <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      mod_k     <= mod_k_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* sv/ddhc_datapath.sv */
`timescale 1ns / 1ps

module ddhc_datapath
  import ddhc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ddhc_cmd_t   cmd,
  input  logic [63:0] in_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic [15:0] compare_right,
  output logic [15:0] compare_left,
  output logic [1:0]  dir_right,
  output logic [1:0]  dir_left
);

  localparam logic signed [17:0] ONE_Q14  = 18'sd16384;
  localparam logic signed [17:0] DUTY_MAX = 18'sd16220;
  localparam logic        [35:0] DEADBAND = 36'd819;
  localparam logic signed [18:0] PI_Q12   = 19'sd12868;
  localparam logic signed [18:0] TWO_PI   = 19'sd25736;
  localparam logic        [23:0] TWO_PI_U = 24'd25736;

  // configuration
  logic [15:0] gain_speed_feedback, gain_speed_target, gain_heading, gain_turn_rate;
  logic [15:0] turn_scale, half_period, pwm_top;

  // state
  logic [15:0]        heading;
  logic signed [23:0] prev_w;

  // working registers
  logic signed [15:0] vs, ht, vl, vr, vt;
  logic signed [41:0] p, acc;
  logic signed [23:0] w;
  logic        [23:0] s;
  logic signed [17:0] err;
  logic signed [25:0] ut;
  logic signed [15:0] ua;
  logic        [14:0] mag_r, mag_l;
  logic        [1:0]  dr_code, dl_code;
  logic        [15:0] cmp_r;

  // shared multiplier
  logic        [15:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [41:0] prod;

  logic signed [15:0] in_vl, in_vr, in_vs, in_ht;
  logic signed [15:0] vl_c, vr_c;
  logic signed [41:0] p_w, p_h, d_u, d_a;
  logic signed [23:0] w_c;
  logic signed [25:0] step;
  logic signed [26:0] s_sum;
  logic        [23:0] mod_sub, s_red;
  logic signed [18:0] ht_x, hd_x, err_x;
  logic signed [35:0] ua_full;
  logic        [35:0] ua_abs;
  logic signed [15:0] ua_c;
  logic signed [17:0] ut1, lim, ut2, dr, dl, dr_c, dl_c, ua18;

  assign in_vs = $signed(in_data[15:0]);
  assign in_ht = $signed(in_data[31:16]);
  assign in_vl = $signed(in_data[47:32]);
  assign in_vr = $signed(in_data[63:48]);

  always_comb begin
    vl_c = in_vl;
    if (in_vl > 16'sd16384) vl_c = 16'sd16384;
    else if (in_vl < -16'sd16384) vl_c = -16'sd16384;
    vr_c = in_vr;
    if (in_vr > 16'sd16384) vr_c = 16'sd16384;
    else if (in_vr < -16'sd16384) vr_c = -16'sd16384;
  end

  always_comb begin
    mul_a = 16'd0;
    mul_b = 25'sd0;
    case (cmd.op)
      OP_MUL_W: begin
        mul_a = turn_scale;
        mul_b = 25'(vr) - 25'(vl);
      end
      OP_MUL_H: begin
        mul_a = half_period;
        mul_b = 25'(w_c) + 25'(prev_w);
      end
      OP_MUL_A: begin
        mul_a = gain_speed_target;
        mul_b = 25'(vs);
      end
      OP_MUL_B: begin
        mul_a = gain_speed_feedback;
        mul_b = 25'(vt);
      end
      OP_MUL_C: begin
        mul_a = gain_heading;
        mul_b = 25'(err);
      end
      OP_MUL_D: begin
        mul_a = gain_turn_rate;
        mul_b = 25'(w);
      end
      OP_MUL_R: begin
        mul_a = pwm_top;
        mul_b = $signed({10'd0, mag_r});
      end
      OP_MUL_L: begin
        mul_a = pwm_top;
        mul_b = $signed({10'd0, mag_l});
      end
      default: begin
        mul_a = 16'd0;
        mul_b = 25'sd0;
      end
    endcase
  end

  assign prod = 42'($signed({1'b0, mul_a})) * 42'(mul_b);

  // round half up: add half an LSB, then shift arithmetically
  assign p_w   = p + 42'sd512;
  assign w_c   = p_w[33:10];
  assign p_h   = p + 42'sd32768;
  assign step  = p_h[41:16];
  assign s_sum = 27'(step) + $signed({11'd0, heading}) + $signed(HEAD_OFFSET);

  assign mod_sub = TWO_PI_U << cmd.mod_k;
  assign s_red   = (s >= mod_sub) ? s - mod_sub : s;

  // shortest heading error
  always_comb begin
    ht_x = 19'(ht);
    hd_x = $signed({3'd0, heading});
    if (ht_x >= hd_x + PI_Q12) err_x = ht_x - TWO_PI - hd_x;
    else if (ht_x <= hd_x - PI_Q12) err_x = ht_x + TWO_PI - hd_x;
    else err_x = ht_x - hd_x;
  end

  assign d_u = acc - p + 42'sd128;
  assign d_a = acc - p + 42'sd32;

  // turn command: saturate, then deadband
  always_comb begin
    ua_full = d_a[41:6];
    ua_abs  = ua_full[35] ? 36'(-ua_full) : 36'(ua_full);
    if (ua_abs > 36'd16384) ua_c = ua_full[35] ? -16'sd16384 : 16'sd16384;
    else if (ua_abs <= DEADBAND) ua_c = 16'sd0;
    else ua_c = ua_full[15:0];
  end

  // forward limit and duty mixing
  always_comb begin
    ut1  = ut[17:0];
    ua18 = 18'(ua);
    lim  = ONE_Q14 - (ua18[17] ? -ua18 : ua18);
    if (ut1 > lim) ut2 = lim;
    else if (ut1 < -lim) ut2 = -lim;
    else ut2 = ut1;
    dr = ut2 + ua18;
    dl = ut2 - ua18;
    if (dr > DUTY_MAX) dr_c = DUTY_MAX;
    else if (dr < -DUTY_MAX) dr_c = -DUTY_MAX;
    else dr_c = dr;
    if (dl > DUTY_MAX) dl_c = DUTY_MAX;
    else if (dl < -DUTY_MAX) dl_c = -DUTY_MAX;
    else dl_c = dl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_speed_feedback <= 16'd256;
      gain_speed_target   <= 16'd256;
      gain_heading        <= 16'd256;
      gain_turn_rate      <= 16'd256;
      turn_scale          <= 16'd256;
      half_period         <= 16'd328;
      pwm_top             <= 16'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_SPEED_FEEDBACK: gain_speed_feedback <= cfg_data;
        REG_GAIN_SPEED_TARGET:   gain_speed_target   <= cfg_data;
        REG_GAIN_HEADING:        gain_heading        <= cfg_data;
        REG_GAIN_TURN_RATE:      gain_turn_rate      <= cfg_data;
        REG_TURN_SCALE:          turn_scale          <= cfg_data;
        REG_HALF_PERIOD:         half_period         <= cfg_data;
        REG_PWM_TOP:             pwm_top             <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heading <= 16'd0;
      prev_w  <= 24'sd0;
    end else begin
      if (cmd.op == OP_MUL_H) prev_w <= w_c;
      if (cmd.op == OP_MOD && cmd.mod_k == 4'd0) heading <= s_red[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      vs <= in_vs;
      ht <= in_ht;
      vl <= vl_c;
      vr <= vr_c;
    end
    case (cmd.op)
      OP_MUL_W: begin
        p  <= prod;
        vt <= 16'((17'(vr) + 17'(vl) + 17'sd1) >>> 1);
      end
      OP_MUL_H: begin
        p <= prod;
        w <= w_c;
      end
      OP_SUM: begin
        s <= s_sum[23:0];
      end
      OP_MOD: begin
        s <= s_red;
      end
      OP_MUL_A: begin
        p   <= prod;
        err <= err_x[17:0];
      end
      OP_MUL_B: begin
        acc <= p;
        p   <= prod;
      end
      OP_MUL_C: begin
        ut <= d_u[33:8];
        p  <= prod;
      end
      OP_MUL_D: begin
        acc <= p;
        p   <= prod;
      end
      OP_LIM_A: begin
        ua <= ua_c;
        if (ut > 26'sd16384) ut <= 26'sd16384;
        else if (ut < -26'sd16384) ut <= -26'sd16384;
      end
      OP_LIM_B: begin
        mag_r   <= dr_c[17] ? 15'(-dr_c) : dr_c[14:0];
        mag_l   <= dl_c[17] ? 15'(-dl_c) : dl_c[14:0];
        dr_code <= (dr_c == 18'sd0) ? DIR_STOP : (dr_c[17] ? DIR_REVERSE : DIR_FORWARD);
        dl_code <= (dl_c == 18'sd0) ? DIR_STOP : (dl_c[17] ? DIR_REVERSE : DIR_FORWARD);
      end
      OP_MUL_R: begin
        p <= prod;
      end
      OP_MUL_L: begin
        cmp_r <= p[29:14];
        p     <= prod;
      end
      OP_OUT: begin
        compare_right <= cmp_r;
        compare_left  <= p[29:14];
        dir_right     <= dr_code;
        dir_left      <= dl_code;
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/differential_drive_heading_control_core.sv */
`timescale 1ns / 1ps

// Differential-drive heading and speed controller. Each input transaction
// carries a target speed, a target heading and the two measured wheel speeds;
// each produces exactly one output transaction with the PWM compare values and
// direction codes of both motors. The block keeps the integrated heading and
// the previous turn rate between transactions, so samples must arrive in
// control-loop order. Between acceptance and the output register a controller
// walks a single shared 17x25 multiplier through eight products, and the
// heading is wrapped into 0..2pi by a nine-step conditional subtract. No new
// sample is taken while one is in flight; the next is taken in the cycle after
// a result enters the output register. A result that is still waiting
// unread when the next one finishes holds the controller, and with it the
// input, until the output register frees. s_tready is high only while the
// controller is idle; a finished result waits in the output register while the
// next sample is taken.
// The gains and scales are written through the cfg channel (index 0..6, as
// listed in the register map); cfg_ready is always high, and writes belong to
// times when no sample is in flight.

module differential_drive_heading_control_core
  import ddhc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // speed_target [15:0], heading_target [31:16], speed_left [47:32],
  // speed_right [63:48]
  input  logic [63:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // compare_right [15:0], compare_left [31:16], dir_right [33:32],
  // dir_left [35:34], zero [39:36]
  output logic [39:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ddhc_cmd_t   cmd;
  logic [15:0] compare_right, compare_left;
  logic [1:0]  dir_right, dir_left;

  // register writes never stall
  assign cfg_ready = 1'b1;

  ddhc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  ddhc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .in_data       (s_tdata),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .compare_right (compare_right),
    .compare_left  (compare_left),
    .dir_right     (dir_right),
    .dir_left      (dir_left)
  );

  // pack the result, padding to whole bytes
  assign m_tdata = {4'd0, dir_left, dir_right, compare_left, compare_right};

endmodule
